// ----- design/mmafb_pkg.sv -----
`timescale 1ns / 1ps

package mmafb_pkg;

    localparam int CHANNELS = 8;
    localparam int WINDOW   = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 8;
    localparam int VAL_W    = 16;
    localparam int STAT_W   = 3;

    localparam int IN_BITS  = CMD_W + IDX_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + IDX_W + VAL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_ADD   = 3'd2,
        CMD_READ  = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_FREE  = 3'd1,
        ST_UNUSED   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

endpackage

// ----- design/multichannel_mma_filter_bank.sv -----
`timescale 1ns / 1ps
// bank of modified moving average channels, one command word in, one result word out
// input stream (s_axis): each word carries a command - allocate the lowest free
//   channel, free, add a sample, read the average, or clear a channel
// output stream (m_axis): one result word per command with status, the channel
//   granted by allocate and the average returned by read
// an add does sum = sum - average + sample and average = sum / WINDOW; a new
//   sum above 65535 reports overflow and leaves the channel as it was
// a command word is captured, then in the execute state its result is registered
//   once the output register is free; a new command is accepted only after the
//   capture then read-modify-write step on the per-channel sum and average registers
// a finished result sits in the output register; the next command is accepted
//   while it waits, and it is only computed once that result is taken
// o_s_axis_tready is low in the execute state, which lasts while the captured
//   command waits behind a stalled receiver
// reset (i_rst_n low, synchronous) frees every channel and zeroes all sums and
//   averages; the block is ready once reset has returned the control to idle
module multichannel_mma_filter_bank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // command[2:0], channel[10:3], sample[26:11], zero fill above
    input  logic [mmafb_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // status[2:0], assigned_channel[10:3], average_out[26:11], zero fill above
    output logic [mmafb_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    localparam int CH_LO = mmafb_pkg::CMD_W;
    localparam int SM_LO = mmafb_pkg::CMD_W + mmafb_pkg::IDX_W;

    mmafb_pkg::t_ctrl_cmd                  cmd;
    logic [mmafb_pkg::STAT_W-1:0]          status;
    logic [mmafb_pkg::IDX_W-1:0]           assigned_channel;
    logic [mmafb_pkg::VAL_W-1:0]           average_out;

    mmafb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    mmafb_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_command          (i_s_axis_tdata[mmafb_pkg::CMD_W-1:0]),
        .i_channel          (i_s_axis_tdata[CH_LO +: mmafb_pkg::IDX_W]),
        .i_sample           (i_s_axis_tdata[SM_LO +: mmafb_pkg::VAL_W]),
        .o_status           (status),
        .o_assigned_channel (assigned_channel),
        .o_average_out      (average_out)
    );

    assign o_m_axis_tdata = mmafb_pkg::OUT_W'({average_out, assigned_channel, status});

endmodule

// ----- design/mmafb_ctrl.sv -----
`timescale 1ns / 1ps

module mmafb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mmafb_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- design/mmafb_dp.sv -----
`timescale 1ns / 1ps

module mmafb_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mmafb_pkg::t_ctrl_cmd               i_cmd,
    input  logic [mmafb_pkg::CMD_W-1:0]        i_command,
    input  logic [mmafb_pkg::IDX_W-1:0]        i_channel,
    input  logic [mmafb_pkg::VAL_W-1:0]        i_sample,
    output logic [mmafb_pkg::STAT_W-1:0]       o_status,
    output logic [mmafb_pkg::IDX_W-1:0]        o_assigned_channel,
    output logic [mmafb_pkg::VAL_W-1:0]        o_average_out
);

    logic [mmafb_pkg::CMD_W-1:0]  r_cmd;
    logic [mmafb_pkg::IDX_W-1:0]  r_ch;
    logic [mmafb_pkg::VAL_W-1:0]  r_smp;

    logic                         r_in_use [mmafb_pkg::CHANNELS];
    logic [mmafb_pkg::VAL_W-1:0]  r_avg    [mmafb_pkg::CHANNELS];
    logic [mmafb_pkg::VAL_W-1:0]  r_sum    [mmafb_pkg::CHANNELS];

    logic [mmafb_pkg::STAT_W-1:0] r_status, n_status;
    logic [mmafb_pkg::IDX_W-1:0]  r_asg, n_asg;
    logic [mmafb_pkg::VAL_W-1:0]  r_avg_out, n_avg_out;

    logic                         ch_ok;
    logic [mmafb_pkg::CH_W-1:0]   ch_idx;
    logic                         sel_used;
    logic [mmafb_pkg::VAL_W-1:0]  sel_sum;
    logic [mmafb_pkg::VAL_W-1:0]  sel_avg;
    logic                         free_found;
    logic [mmafb_pkg::CH_W-1:0]   free_idx;
    logic [mmafb_pkg::VAL_W:0]    new_sum;

    logic                         wr_en;
    logic [mmafb_pkg::CH_W-1:0]   wr_idx;
    logic                         n_use;
    logic [mmafb_pkg::VAL_W-1:0]  n_sum;
    logic [mmafb_pkg::VAL_W-1:0]  n_avg;

    assign ch_ok    = (int'(r_ch) < mmafb_pkg::CHANNELS);
    assign ch_idx   = r_ch[mmafb_pkg::CH_W-1:0];
    assign sel_used = r_in_use[ch_idx];
    assign sel_sum  = r_sum[ch_idx];
    assign sel_avg  = r_avg[ch_idx];

    // average never exceeds sum, so the difference stays non-negative
    assign new_sum = {1'b0, sel_sum} - {1'b0, sel_avg} + {1'b0, r_smp};

    // lowest free channel
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = mmafb_pkg::CHANNELS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_found = 1'b1;
                free_idx   = mmafb_pkg::CH_W'(i);
            end
        end
    end

    always_comb begin
        n_status  = mmafb_pkg::ST_OK;
        n_asg     = '0;
        n_avg_out = '0;
        wr_en     = 1'b0;
        wr_idx    = ch_idx;
        n_use     = sel_used;
        n_sum     = sel_sum;
        n_avg     = sel_avg;
        case (r_cmd)
            mmafb_pkg::CMD_ALLOC: begin
                if (free_found) begin
                    wr_en  = 1'b1;
                    wr_idx = free_idx;
                    n_use  = 1'b1;
                    n_sum  = '0;
                    n_avg  = '0;
                    n_asg  = mmafb_pkg::IDX_W'(free_idx);
                end else begin
                    n_status = mmafb_pkg::ST_NO_FREE;
                end
            end
            mmafb_pkg::CMD_FREE, mmafb_pkg::CMD_ADD,
            mmafb_pkg::CMD_READ, mmafb_pkg::CMD_CLEAR: begin
                if (!ch_ok) begin
                    n_status = mmafb_pkg::ST_RANGE;
                end else if (!sel_used) begin
                    n_status = mmafb_pkg::ST_UNUSED;
                end else if (r_cmd == mmafb_pkg::CMD_FREE) begin
                    wr_en = 1'b1;
                    n_use = 1'b0;
                    n_sum = '0;
                    n_avg = '0;
                end else if (r_cmd == mmafb_pkg::CMD_ADD) begin
                    if (new_sum[mmafb_pkg::VAL_W]) begin
                        n_status = mmafb_pkg::ST_OVERFLOW;
                    end else begin
                        wr_en = 1'b1;
                        n_sum = new_sum[mmafb_pkg::VAL_W-1:0];
                        n_avg = mmafb_pkg::VAL_W'(
                            new_sum[mmafb_pkg::VAL_W-1:0] / mmafb_pkg::WINDOW);
                    end
                end else if (r_cmd == mmafb_pkg::CMD_READ) begin
                    n_avg_out = sel_avg;
                end else begin
                    wr_en = 1'b1;
                    n_sum = '0;
                    n_avg = '0;
                end
            end
            default: begin
                n_status = mmafb_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_ch  <= i_channel;
            r_smp <= i_sample;
        end
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_asg     <= n_asg;
            r_avg_out <= n_avg_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mmafb_pkg::CHANNELS; i++) begin
                r_in_use[i] <= 1'b0;
                r_avg[i]    <= '0;
                r_sum[i]    <= '0;
            end
        end else if (i_cmd.commit && wr_en) begin
            r_in_use[wr_idx] <= n_use;
            r_avg[wr_idx]    <= n_avg;
            r_sum[wr_idx]    <= n_sum;
        end
    end

    assign o_status           = r_status;
    assign o_assigned_channel = r_asg;
    assign o_average_out      = r_avg_out;

endmodule
